[rtl/cps_pkg.sv]
`timescale 1ns / 1ps
package cps_pkg;

   // Sizing defaults and fixed field widths
   localparam int MAX_POINTS_DEF  = 4096;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int COORD_W         = 16;
   localparam int EPS_W           = 16;
   localparam int VIDX_W          = 12;

   // Shared multiplier: 17x17 signed
   localparam int MUL_W  = COORD_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   // Serial multiplier operand width (cross magnitude, squared chord length, eps squared)
   localparam int SMUL_W = PROD_W;

   // Register map
   localparam int               CSR_ADDR_W   = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_EPS_ADDR = 2'd0;
   localparam logic [EPS_W-1:0] EPS_RESET    = 16'd256;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      last_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic [VIDX_W-1:0]         vertex_index;
      logic                      last_vertex;
      logic                      overflow;
   } rsp_type;

endpackage

[rtl/cps_divider.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module cps_divider import cps_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [COORD_W+$clog2(MAX_POINTS)-1:0] dividend,
   input  logic [$clog2(MAX_POINTS):0]        divisor,
   output logic                               done,
   output logic signed [COORD_W-1:0]          quotient
);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = IDX_W + 1;
   localparam int SUM_W = COORD_W + IDX_W;
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic              neg_ff, neg_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W:0]    rem_sh;
   logic [SUM_W-1:0]  quo_neg;

   // One shift-and-subtract step per cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      step_in = step_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         div_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         run_in  = 1'b1;
         step_in = '0;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(rem_sh - {1'b0, div_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

   assign quo_neg  = SUM_W'(-quo_ff);
   assign done     = done_ff;
   assign quotient = neg_ff ? quo_neg[COORD_W-1:0] : quo_ff[COORD_W-1:0];

endmodule

[rtl/cps_smul.sv]
`timescale 1ns / 1ps
// Shift-add multiplier, unsigned, one multiplier bit per cycle.
module cps_smul import cps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SMUL_W-1:0]     op_a,
   input  logic [SMUL_W-1:0]     op_b,
   output logic                  done,
   output logic [2*SMUL_W-1:0]   product
);
   localparam int STEP_W = $clog2(SMUL_W + 1);

   logic [2*SMUL_W-1:0] acc_ff, acc_in;
   logic [2*SMUL_W-1:0] a_ff, a_in;
   logic [SMUL_W-1:0]   b_ff, b_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      run_in  = run_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = {{SMUL_W{1'b0}}, op_a};
         b_in    = op_b;
         run_in  = 1'b1;
         step_in = '0;
      end else if (run_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in    = {a_ff[2*SMUL_W-2:0], 1'b0};
         b_in    = {1'b0, b_ff[SMUL_W-1:1]};
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(SMUL_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      step_ff <= step_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[rtl/contour_polygon_simplifier.sv]
`timescale 1ns / 1ps
// Channel   | ports                                  | beat taken when
// ----------+----------------------------------------+------------------------------
// points in | start, busy, req_data                  | start && !busy
// vertices  | rsp_valid, rsp_data                    | rsp_valid (one cycle, no stall)
// config    | csr_psel/penable/pwrite/paddr/pwdata   | psel && penable && pwrite
//
// A point that is not last leaves the block idle, ready for the next point.
// The last point starts the run: two divides for the centroid, a search for
// the farthest point, per span a scan of its interior points and a tolerance
// test on the serial multiplier, then the emission of the kept vertices. The
// shared 17x17 multiplier and the serial multiplier do the arithmetic. Reset
// is synchronous; no clearing pass is needed.
module contour_polygon_simplifier import cps_pkg::*; #(
   parameter int MAX_POINTS  = MAX_POINTS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = IDX_W + 1;
   localparam int SUM_W = COORD_W + IDX_W;
   localparam int SP_W  = $clog2(STACK_DEPTH);
   localparam int ST_W  = $clog2(STACK_DEPTH + 1);

   typedef enum logic [32:0] {
      ST_IDLE  = 33'h000000001,
      ST_DXS   = 33'h000000002,
      ST_DXW   = 33'h000000004,
      ST_DYS   = 33'h000000008,
      ST_DYW   = 33'h000000010,
      ST_FA    = 33'h000000020,
      ST_FB    = 33'h000000040,
      ST_FC    = 33'h000000080,
      ST_FD    = 33'h000000100,
      ST_FE    = 33'h000000200,
      ST_SINIT = 33'h000000400,
      ST_SR    = 33'h000000800,
      ST_SL    = 33'h000001000,
      ST_SK    = 33'h000002000,
      ST_SA    = 33'h000004000,
      ST_SC1   = 33'h000008000,
      ST_SC2   = 33'h000010000,
      ST_SC3   = 33'h000020000,
      ST_SI    = 33'h000040000,
      ST_SJ    = 33'h000080000,
      ST_SM1   = 33'h000100000,
      ST_SM2   = 33'h000200000,
      ST_SM3   = 33'h000400000,
      ST_SE    = 33'h000800000,
      ST_QS    = 33'h001000000,
      ST_QW    = 33'h002000000,
      ST_PS    = 33'h004000000,
      ST_PW    = 33'h008000000,
      ST_SCL   = 33'h010000000,
      ST_SOP   = 33'h020000000,
      ST_EA    = 33'h040000000,
      ST_EB    = 33'h080000000,
      ST_EC    = 33'h100000000
   } state_type;

   state_type state_ff, state_in;

   // Memories
   logic [2*COORD_W-1:0] pmem [MAX_POINTS];
   logic [IDX_W-1:0]     ostk [STACK_DEPTH];
   logic [IDX_W-1:0]     cstk [STACK_DEPTH];
   logic [2*COORD_W-1:0] prd_ff;
   logic [IDX_W-1:0]     ord_ff, crd_ff;

   logic                 pm_we;
   logic [IDX_W-1:0]     pm_waddr, pm_raddr;
   logic                 os_we, cs_we;
   logic [SP_W-1:0]      os_waddr, cs_waddr, os_raddr, cs_raddr;
   logic [IDX_W-1:0]     os_wdata, cs_wdata;

   // Control and data registers
   logic [EPS_W-1:0]        eps_ff, eps_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sumx_ff, sumx_in, sumy_ff, sumy_in;
   logic                    lost_ff, lost_in;
   logic                    ovf_ff, ovf_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [COORD_W-1:0] lx_ff, lx_in, ly_ff, ly_in;
   logic signed [MUL_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [MUL_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [PROD_W-1:0] mul_ff, sq_ff, sq_in;
   logic [PROD_W-1:0]       best_ff, best_in, top_ff, top_in, chord_ff, chord_in;
   logic [2*SMUL_W-1:0]     crs2_ff, crs2_in;
   logic [IDX_W-1:0]        rot_ff, rot_in, n_ff, n_in, k_ff, k_in, l_ff, l_in;
   logic [IDX_W-1:0]        nmax_ff, nmax_in, idx_ff, idx_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic [ST_W-1:0]         otop_ff, otop_in, ctop_ff, ctop_in;
   logic [ST_W-1:0]         nemit_ff, nemit_in, r_ff, r_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Shared multiplier operands
   logic                    mul_en;
   logic signed [MUL_W-1:0] mul_a, mul_b;

   // Fetch with rotation
   logic [IDX_W-1:0] fetch_i;
   logic             use_rot;
   logic [CNT_W-1:0] jsum, jadj;

   // Helpers
   logic                    accept, csr_wr;
   logic [CNT_W-1:0]        cnt_new, m_val;
   logic signed [COORD_W-1:0] px, py;
   logic signed [PROD_W:0]  cross_v, cross_abs;
   logic [PROD_W-1:0]       dist_v;
   logic [ST_W-1:0]         otop_dec;
   logic [IDX_W+VIDX_W-1:0] idx_ext;
   logic [2*SMUL_W+15:0]    lhs_cmp, rhs_cmp;

   // Divider and serial multiplier
   logic                    div_start, div_done;
   logic signed [SUM_W-1:0] div_num;
   logic signed [COORD_W-1:0] div_q;
   logic                    sm_start, sm_done;
   logic [SMUL_W-1:0]       sm_a, sm_b;
   logic [2*SMUL_W-1:0]     sm_p;

   cps_divider #(.MAX_POINTS(MAX_POINTS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   cps_smul u_smul (
      .clock   (clock),
      .reset   (reset),
      .start   (sm_start),
      .op_a    (sm_a),
      .op_b    (sm_b),
      .done    (sm_done),
      .product (sm_p)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_EPS_ADDR);
   assign cnt_new  = (cnt_ff < CNT_W'(MAX_POINTS)) ? CNT_W'(cnt_ff + 1'b1) : cnt_ff;
   assign px       = prd_ff[COORD_W-1:0];
   assign py       = prd_ff[2*COORD_W-1:COORD_W];
   assign m_val    = (k_ff == '0) ? cnt_ff : {1'b0, k_ff};
   assign otop_dec = ST_W'(otop_ff - 1'b1);
   assign div_num  = (state_ff == ST_DXS) ? sumx_ff : sumy_ff;
   assign div_start = (state_ff == ST_DXS) || (state_ff == ST_DYS);
   assign sm_start = (state_ff == ST_QS) || (state_ff == ST_PS);
   assign sm_a     = (state_ff == ST_QS) ? top_ff : chord_ff;
   assign sm_b     = (state_ff == ST_QS) ? top_ff : SMUL_W'(mul_ff);
   assign cross_v  = {sq_ff[PROD_W-1], sq_ff} - {mul_ff[PROD_W-1], mul_ff};
   assign cross_abs = cross_v[PROD_W] ? (PROD_W+1)'(-cross_v) : cross_v;
   assign dist_v   = PROD_W'(sq_ff) + PROD_W'(mul_ff);
   assign lhs_cmp  = {crs2_ff, 16'b0};
   assign rhs_cmp  = {16'b0, sm_p};
   assign idx_ext  = (IDX_W+VIDX_W)'(idx_ff);

   // Rotated point address
   assign jsum     = {1'b0, fetch_i} + {1'b0, (use_rot ? rot_ff : {IDX_W{1'b0}})};
   assign jadj     = (jsum >= cnt_ff) ? CNT_W'(jsum - cnt_ff) : jsum;
   assign pm_raddr = jadj[IDX_W-1:0];

   // Fetch index and multiplier operand select
   always_comb begin
      fetch_i = i_ff[IDX_W-1:0];
      use_rot = 1'b1;
      mul_en  = 1'b1;
      mul_a   = dx_ff;
      mul_b   = dx_ff;
      unique case (state_ff)
         ST_FA: use_rot = 1'b0;
         ST_SL: fetch_i = crd_ff;
         ST_SK: fetch_i = k_ff;
         ST_EB: fetch_i = crd_ff;
         ST_FD: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         ST_SC1: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         ST_SC2: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         ST_SM1: begin
            mul_a = ax_ff;
            mul_b = dy_ff;
         end
         ST_SM2: begin
            mul_a = ay_ff;
            mul_b = dx_ff;
         end
         ST_SE: begin
            mul_a = MUL_W'(signed'({1'b0, eps_ff}));
            mul_b = MUL_W'(signed'({1'b0, eps_ff}));
         end
         ST_FC: ;
         default: mul_en = 1'b0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      eps_in    = csr_wr ? csr_pwdata[EPS_W-1:0] : eps_ff;
      cnt_in    = cnt_ff;
      sumx_in   = sumx_ff;
      sumy_in   = sumy_ff;
      lost_in   = lost_ff;
      ovf_in    = ovf_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      lx_in     = lx_ff;
      ly_in     = ly_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      sq_in     = sq_ff;
      best_in   = best_ff;
      top_in    = top_ff;
      chord_in  = chord_ff;
      crs2_in   = crs2_ff;
      rot_in    = rot_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      l_in      = l_ff;
      nmax_in   = nmax_ff;
      idx_in    = idx_ff;
      i_in      = i_ff;
      otop_in   = otop_ff;
      ctop_in   = ctop_ff;
      nemit_in  = nemit_ff;
      r_in      = r_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      pm_we     = 1'b0;
      pm_waddr  = cnt_ff[IDX_W-1:0];
      os_we     = 1'b0;
      os_waddr  = otop_ff[SP_W-1:0];
      os_wdata  = nmax_ff;
      cs_we     = 1'b0;
      cs_waddr  = ctop_ff[SP_W-1:0];
      cs_wdata  = k_ff;
      os_raddr  = otop_dec[SP_W-1:0];
      cs_raddr  = (state_ff == ST_EA) ? r_ff[SP_W-1:0] : SP_W'(ctop_ff - 1'b1);

      unique case (state_ff)
         // Point load
         ST_IDLE: begin
            if (accept) begin
               if (cnt_ff < CNT_W'(MAX_POINTS)) begin
                  pm_we   = 1'b1;
                  sumx_in = sumx_ff + SUM_W'(req_data.point_x);
                  sumy_in = sumy_ff + SUM_W'(req_data.point_y);
               end else begin
                  lost_in = 1'b1;
               end
               cnt_in = cnt_new;
               if (req_data.last_point) begin
                  rot_in = '0;
                  ovf_in = lost_in;
                  r_in   = '0;
                  if (cnt_new < CNT_W'(2)) begin
                     cs_we    = 1'b1;
                     cs_waddr = '0;
                     cs_wdata = '0;
                     nemit_in = ST_W'(1);
                     state_in = ST_EA;
                  end else begin
                     state_in = ST_DXS;
                  end
               end
            end
         end
         // Centroid
         ST_DXS: state_in = ST_DXW;
         ST_DXW: begin
            if (div_done) begin
               cx_in    = div_q;
               state_in = ST_DYS;
            end
         end
         ST_DYS: state_in = ST_DYW;
         ST_DYW: begin
            if (div_done) begin
               cy_in    = div_q;
               i_in     = '0;
               state_in = ST_FA;
            end
         end
         // Farthest point search
         ST_FA: state_in = ST_FB;
         ST_FB: begin
            dx_in    = MUL_W'(cx_ff) - MUL_W'(px);
            dy_in    = MUL_W'(cy_ff) - MUL_W'(py);
            state_in = ST_FC;
         end
         ST_FC: state_in = ST_FD;
         ST_FD: begin
            sq_in    = mul_ff;
            state_in = ST_FE;
         end
         ST_FE: begin
            if ((i_ff == '0) || (dist_v > best_ff)) begin
               best_in = dist_v;
               rot_in  = i_ff[IDX_W-1:0];
            end
            if (i_ff == CNT_W'(cnt_ff - 1'b1)) begin
               state_in = ST_SINIT;
            end else begin
               i_in     = CNT_W'(i_ff + 1'b1);
               state_in = ST_FA;
            end
         end
         // Split setup
         ST_SINIT: begin
            n_in     = cnt_ff[IDX_W:1];
            cs_we    = 1'b1;
            cs_waddr = '0;
            cs_wdata = '0;
            os_we    = 1'b1;
            os_waddr = '0;
            os_wdata = cnt_ff[IDX_W:1];
            ctop_in  = ST_W'(1);
            otop_in  = ST_W'(1);
            state_in = ST_SR;
         end
         // Span endpoints
         ST_SR: state_in = ST_SL;
         ST_SL: begin
            k_in     = ord_ff;
            l_in     = crd_ff;
            state_in = ST_SK;
         end
         ST_SK: begin
            lx_in    = px;
            ly_in    = py;
            state_in = ST_SA;
         end
         ST_SA: begin
            ax_in    = MUL_W'(px) - MUL_W'(lx_ff);
            ay_in    = MUL_W'(py) - MUL_W'(ly_ff);
            state_in = ST_SC1;
         end
         ST_SC1: state_in = ST_SC2;
         ST_SC2: begin
            sq_in    = mul_ff;
            state_in = ST_SC3;
         end
         ST_SC3: begin
            chord_in = dist_v;
            i_in     = CNT_W'({1'b0, l_ff} + 1'b1);
            top_in   = '0;
            nmax_in  = l_ff;
            state_in = ST_SI;
         end
         // Interior scan
         ST_SI: state_in = (i_ff >= m_val) ? ST_SE : ST_SJ;
         ST_SJ: begin
            dy_in    = MUL_W'(ly_ff) - MUL_W'(py);
            dx_in    = MUL_W'(lx_ff) - MUL_W'(px);
            state_in = ST_SM1;
         end
         ST_SM1: state_in = ST_SM2;
         ST_SM2: begin
            sq_in    = mul_ff;
            state_in = ST_SM3;
         end
         ST_SM3: begin
            if (cross_abs[PROD_W-1:0] > top_ff) begin
               top_in  = cross_abs[PROD_W-1:0];
               nmax_in = i_ff[IDX_W-1:0];
            end
            i_in     = CNT_W'(i_ff + 1'b1);
            state_in = ST_SI;
         end
         // Tolerance test
         ST_SE: state_in = (top_ff == '0) ? ST_SCL : ST_QS;
         ST_QS: state_in = ST_QW;
         ST_QW: begin
            if (sm_done) begin
               crs2_in  = sm_p;
               state_in = ST_PS;
            end
         end
         ST_PS: state_in = ST_PW;
         ST_PW: begin
            if (sm_done) state_in = (lhs_cmp < rhs_cmp) ? ST_SCL : ST_SOP;
         end
         // Close span
         ST_SCL: begin
            if (ctop_ff >= ST_W'(STACK_DEPTH)) begin
               ovf_in   = 1'b1;
               nemit_in = ctop_ff;
               r_in     = '0;
               state_in = ST_EA;
            end else if (otop_dec == '0) begin
               if (k_ff == n_ff) begin
                  // first half done: start the wrap-around span to point 0
                  os_we    = 1'b1;
                  os_waddr = '0;
                  os_wdata = '0;
                  otop_in  = ST_W'(1);
                  state_in = ST_SR;
               end else begin
                  nemit_in = ctop_ff;
                  r_in     = '0;
                  state_in = ST_EA;
               end
            end else begin
               cs_we    = 1'b1;
               ctop_in  = ST_W'(ctop_ff + 1'b1);
               otop_in  = otop_dec;
               state_in = ST_SR;
            end
         end
         // Open span at farthest point
         ST_SOP: begin
            if (otop_ff >= ST_W'(STACK_DEPTH)) begin
               ovf_in   = 1'b1;
               nemit_in = ctop_ff;
               r_in     = '0;
               state_in = ST_EA;
            end else begin
               os_we    = 1'b1;
               otop_in  = ST_W'(otop_ff + 1'b1);
               state_in = ST_SR;
            end
         end
         // Emit kept vertices
         ST_EA: begin
            if (r_ff == nemit_ff) begin
               cnt_in   = '0;
               sumx_in  = '0;
               sumy_in  = '0;
               lost_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EB;
            end
         end
         ST_EB: begin
            idx_in   = crd_ff;
            state_in = ST_EC;
         end
         ST_EC: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.vertex_x     = px;
            rsp_data_in.vertex_y     = py;
            rsp_data_in.vertex_index = idx_ext[VIDX_W-1:0];
            rsp_data_in.last_vertex  = (ST_W'(r_ff + 1'b1) == nemit_ff);
            rsp_data_in.overflow     = ovf_ff;
            r_in                     = ST_W'(r_ff + 1'b1);
            state_in                 = ST_EA;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memories, registered reads
   always_ff @(posedge clock) begin
      if (pm_we) pmem[pm_waddr] <= {req_data.point_y, req_data.point_x};
      prd_ff <= pmem[pm_raddr];
      if (os_we) ostk[os_waddr] <= os_wdata;
      ord_ff <= ostk[os_raddr];
      if (cs_we) cstk[cs_waddr] <= cs_wdata;
      crd_ff <= cstk[cs_raddr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eps_ff       <= EPS_RESET;
         cnt_ff       <= '0;
         sumx_ff      <= '0;
         sumy_ff      <= '0;
         lost_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eps_ff       <= eps_in;
         cnt_ff       <= cnt_in;
         sumx_ff      <= sumx_in;
         sumy_ff      <= sumy_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (mul_en) mul_ff <= mul_a * mul_b;
      ovf_ff      <= ovf_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      lx_ff       <= lx_in;
      ly_ff       <= ly_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      sq_ff       <= sq_in;
      best_ff     <= best_in;
      top_ff      <= top_in;
      chord_ff    <= chord_in;
      crs2_ff     <= crs2_in;
      rot_ff      <= rot_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      l_ff        <= l_in;
      nmax_ff     <= nmax_in;
      idx_ff      <= idx_in;
      i_ff        <= i_in;
      otop_ff     <= otop_in;
      ctop_ff     <= ctop_in;
      nemit_ff    <= nemit_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_EPS_ADDR) ? {16'b0, eps_ff} : 32'b0;

endmodule
